FILE: rtl/assert_macros.svh
// Assertion macros shared by the video register block RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CGB_ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CGB_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CGB_ASSERT_PROP(label, clk, rst_n, prop)
`define CGB_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/cgbph_pkg.sv
// Package for the palette and HDMA register block: operation and register codes,
// the control and status structs between modules, and the 5-to-8-bit color table.
// Depends on nothing.
`timescale 1ns / 1ps
package cgbph_pkg;

  localparam int PALETTE_BYTES = 64;
  localparam int PAL_IDX_W     = $clog2(PALETTE_BYTES);
  localparam int PAL_WORDS     = PALETTE_BYTES / 2;
  localparam int PAL_WADDR_W   = $clog2(PAL_WORDS);

  typedef logic [1:0] op_t;
  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_COPY  = 2'd2;

  typedef logic [3:0] sel_t;
  localparam sel_t SEL_VBK   = 4'd0;
  localparam sel_t SEL_HDMA1 = 4'd1;
  localparam sel_t SEL_HDMA2 = 4'd2;
  localparam sel_t SEL_HDMA3 = 4'd3;
  localparam sel_t SEL_HDMA4 = 4'd4;
  localparam sel_t SEL_HDMA5 = 4'd5;
  localparam sel_t SEL_BCPS  = 4'd6;
  localparam sel_t SEL_BCPD  = 4'd7;
  localparam sel_t SEL_OCPS  = 4'd8;
  localparam sel_t SEL_OCPD  = 4'd9;

  typedef struct packed {
    logic [3:0] latch_we;
    logic       hdma5_we;
    logic       step;
  } hdma_ctl_t;

  typedef struct packed {
    logic active;
    logic copy_valid;
    logic done;
  } hdma_status_t;

  typedef struct packed {
    logic [2:0]  palette_number;
    logic [1:0]  color_number;
    logic [23:0] rgb;
  } pal_upd_t;

  // Each entry is floor(c * 255 / 31).
  function automatic logic [7:0] chan8(input logic [4:0] c);
    logic [7:0] v;
    case (c)
      5'd0:  v = 8'd0;
      5'd1:  v = 8'd8;
      5'd2:  v = 8'd16;
      5'd3:  v = 8'd24;
      5'd4:  v = 8'd32;
      5'd5:  v = 8'd41;
      5'd6:  v = 8'd49;
      5'd7:  v = 8'd57;
      5'd8:  v = 8'd65;
      5'd9:  v = 8'd74;
      5'd10: v = 8'd82;
      5'd11: v = 8'd90;
      5'd12: v = 8'd98;
      5'd13: v = 8'd106;
      5'd14: v = 8'd115;
      5'd15: v = 8'd123;
      5'd16: v = 8'd131;
      5'd17: v = 8'd139;
      5'd18: v = 8'd148;
      5'd19: v = 8'd156;
      5'd20: v = 8'd164;
      5'd21: v = 8'd172;
      5'd22: v = 8'd180;
      5'd23: v = 8'd189;
      5'd24: v = 8'd197;
      5'd25: v = 8'd205;
      5'd26: v = 8'd213;
      5'd27: v = 8'd222;
      5'd28: v = 8'd230;
      5'd29: v = 8'd238;
      5'd30: v = 8'd246;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/cgbph_palette.sv
// One color palette RAM, held as 16-bit color words, with its auto-incrementing
// index register and RGB555 to RGB888 conversion. Uses cgbph_pkg.
`timescale 1ns / 1ps
module cgbph_palette (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               idx_we,
  input  logic               data_we,
  input  logic [7:0]         wdata,
  output logic [7:0]         index,
  output logic [7:0]         rd_byte,
  output cgbph_pkg::pal_upd_t upd
);
  import cgbph_pkg::*;

  logic [7:0]             index_r, index_nxt;
  logic [15:0]            words_r [PAL_WORDS];
  logic [PAL_WADDR_W-1:0] waddr;
  logic [PAL_IDX_W-1:0]   idx;
  logic [15:0]            cur_word, new_word;

  assign idx      = index_r[PAL_IDX_W-1:0];
  assign waddr    = idx[PAL_IDX_W-1:1];
  assign cur_word = words_r[waddr];
  assign rd_byte  = idx[0] ? cur_word[15:8] : cur_word[7:0];
  assign index    = index_r;

  always_comb begin
    new_word = cur_word;
    if (idx[0]) begin
      new_word[15:8] = wdata;
    end else begin
      new_word[7:0] = wdata;
    end
  end

  assign upd.palette_number = idx[5:3];
  assign upd.color_number   = idx[2:1];
  assign upd.rgb            = {chan8(new_word[4:0]), chan8(new_word[9:5]),
                               chan8(new_word[14:10])};

  always_comb begin
    index_nxt = index_r;
    if (idx_we) begin
      index_nxt = wdata;
    end else if (data_we && index_r[7]) begin
      index_nxt = {2'b10, 6'(idx + 1'b1)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      for (int i = 0; i < PAL_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      index_r <= index_nxt;
      if (data_we) begin
        words_r[waddr] <= new_word;
      end
    end
  end

endmodule

FILE: rtl/cgbph_hdma.sv
// HDMA source and destination latches, start, cancel and status, and the
// per-step copy address generator. Uses cgbph_pkg.
`timescale 1ns / 1ps
module cgbph_hdma (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cgbph_pkg::hdma_ctl_t   ctl,
  input  logic [7:0]             wdata,
  output logic [7:0]             src_high,
  output logic [7:0]             src_low,
  output logic [7:0]             dst_high,
  output logic [7:0]             dst_low,
  output logic [7:0]             status,
  output logic [15:0]            copy_src,
  output logic [15:0]            copy_dst,
  output cgbph_pkg::hdma_status_t stat
);
  import cgbph_pkg::*;

  logic [7:0]  src_high_r, src_low_r, dst_high_r, dst_low_r;
  logic [15:0] src_addr_r, src_addr_nxt, dst_addr_r, dst_addr_nxt;
  logic [11:0] left_r, left_nxt;
  logic        active_r, active_nxt;
  logic        cancel, start, step_ok, last;
  logic [7:0]  blocks;

  assign cancel  = ctl.hdma5_we && wdata[7] && active_r;
  assign start   = ctl.hdma5_we && !cancel;
  assign step_ok = ctl.step && active_r && (left_r != '0);
  assign last    = step_ok && (left_r == 12'd1);
  assign blocks  = {1'b0, wdata[6:0]} + 8'd1;

  assign stat.active     = active_r;
  assign stat.copy_valid = step_ok;
  assign stat.done       = cancel || last;

  assign src_high = src_high_r;
  assign src_low  = src_low_r;
  assign dst_high = dst_high_r;
  assign dst_low  = dst_low_r;
  assign status   = active_r ? (left_r[11:4] - 8'd1) : 8'hFF;
  assign copy_src = src_addr_r;
  assign copy_dst = dst_addr_r;

  always_comb begin
    src_addr_nxt = src_addr_r;
    dst_addr_nxt = dst_addr_r;
    left_nxt     = left_r;
    active_nxt   = active_r;
    if (cancel) begin
      active_nxt = 1'b0;
    end else if (start) begin
      src_addr_nxt = {src_high_r, src_low_r} & 16'hFFF0;
      dst_addr_nxt = ({dst_high_r, dst_low_r} & 16'h1FF0) | 16'h8000;
      left_nxt     = {blocks, 4'b0000};
      active_nxt   = 1'b1;
    end else if (step_ok) begin
      src_addr_nxt = src_addr_r + 16'd1;
      dst_addr_nxt = dst_addr_r + 16'd1;
      left_nxt     = left_r - 12'd1;
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_high_r <= '0;
      src_low_r  <= '0;
      dst_high_r <= '0;
      dst_low_r  <= '0;
      src_addr_r <= '0;
      dst_addr_r <= '0;
      left_r     <= '0;
      active_r   <= 1'b0;
    end else begin
      if (ctl.latch_we[0]) src_high_r <= wdata;
      if (ctl.latch_we[1]) src_low_r  <= wdata & 8'hF0;
      if (ctl.latch_we[2]) dst_high_r <= wdata & 8'h1F;
      if (ctl.latch_we[3]) dst_low_r  <= wdata & 8'hF0;
      src_addr_r <= src_addr_nxt;
      dst_addr_r <= dst_addr_nxt;
      left_r     <= left_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

FILE: rtl/cgb_palette_and_hdma_regs.sv
// Top level of the color video register block: VRAM bank, HDMA and palette RAMs.
// Instantiates cgbph_palette twice and cgbph_hdma; uses cgbph_pkg and assert_macros.svh.
//
// The in_ channel carries one request: a register read, a register write or one
// HDMA copy step. Every accepted request yields exactly one result on the out_
// channel in the cycle after acceptance, held in an output register until taken.
// Throughput is one request per cycle: all decoding, palette lookup, color
// conversion and address stepping happen combinationally ahead of the output
// register. in_ready is high whenever the output register is empty or
// is being taken in the same cycle, so a stalled receiver holds the pending
// result and stops new requests until it takes it.
// The cfg_ channel writes the color mode bit; it is always ready and should
// only be written while no request is outstanding.
// Reset (rst_n low, synchronous) clears all palette entries, indexes, HDMA
// latches and state, empties the output register and sets color mode to 1.
`timescale 1ns / 1ps
module cgb_palette_and_hdma_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_register_select,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_palette_update,
  output logic        out_palette_is_obj,
  output logic [2:0]  out_palette_number,
  output logic [1:0]  out_color_number,
  output logic [23:0] out_color_rgb,
  output logic        out_copy_valid,
  output logic [15:0] out_copy_source,
  output logic [15:0] out_copy_dest,
  output logic        out_transfer_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_color_mode
);
  import cgbph_pkg::*;
  `include "assert_macros.svh"

  logic         in_fire, is_rd, is_wr;
  logic         color_mode_r, vram_bank_r;
  hdma_ctl_t    hctl;
  hdma_status_t hstat;
  logic [7:0]   h_src_high, h_src_low, h_dst_high, h_dst_low, h_status;
  logic [15:0]  h_copy_src, h_copy_dst;
  logic         bg_idx_we, bg_data_we, obj_idx_we, obj_data_we;
  logic [7:0]   bg_index, bg_rd, obj_index, obj_rd;
  pal_upd_t     bg_upd, obj_upd;
  logic [7:0]   rd_mux;

  logic         out_valid_r;
  logic [7:0]   read_data_r, read_data_nxt;
  logic         pal_update_r, pal_update_nxt, pal_obj_r, pal_obj_nxt;
  pal_upd_t     pal_r, pal_nxt;
  logic         copy_valid_r;
  logic [15:0]  copy_src_r, copy_src_nxt, copy_dst_r, copy_dst_nxt;
  logic         done_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign is_rd     = in_fire && (in_operation == OP_READ);
  assign is_wr     = in_fire && (in_operation == OP_WRITE);

  always_comb begin
    hctl.latch_we[0] = is_wr && (in_register_select == SEL_HDMA1);
    hctl.latch_we[1] = is_wr && (in_register_select == SEL_HDMA2);
    hctl.latch_we[2] = is_wr && (in_register_select == SEL_HDMA3);
    hctl.latch_we[3] = is_wr && (in_register_select == SEL_HDMA4);
    hctl.hdma5_we    = is_wr && color_mode_r && (in_register_select == SEL_HDMA5);
    hctl.step        = in_fire && (in_operation == OP_COPY);
  end

  assign bg_idx_we   = is_wr && (in_register_select == SEL_BCPS);
  assign bg_data_we  = is_wr && color_mode_r && (in_register_select == SEL_BCPD);
  assign obj_idx_we  = is_wr && (in_register_select == SEL_OCPS);
  assign obj_data_we = is_wr && color_mode_r && (in_register_select == SEL_OCPD);

  cgbph_hdma u_hdma (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .wdata    (in_write_data),
    .src_high (h_src_high),
    .src_low  (h_src_low),
    .dst_high (h_dst_high),
    .dst_low  (h_dst_low),
    .status   (h_status),
    .copy_src (h_copy_src),
    .copy_dst (h_copy_dst),
    .stat     (hstat)
  );

  cgbph_palette u_bg_pal (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx_we  (bg_idx_we),
    .data_we (bg_data_we),
    .wdata   (in_write_data),
    .index   (bg_index),
    .rd_byte (bg_rd),
    .upd     (bg_upd)
  );

  cgbph_palette u_obj_pal (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx_we  (obj_idx_we),
    .data_we (obj_data_we),
    .wdata   (in_write_data),
    .index   (obj_index),
    .rd_byte (obj_rd),
    .upd     (obj_upd)
  );

  always_comb begin
    unique case (in_register_select)
      SEL_VBK:   rd_mux = {7'h7F, vram_bank_r};
      SEL_HDMA1: rd_mux = h_src_high;
      SEL_HDMA2: rd_mux = h_src_low;
      SEL_HDMA3: rd_mux = h_dst_high;
      SEL_HDMA4: rd_mux = h_dst_low;
      SEL_HDMA5: rd_mux = h_status;
      SEL_BCPS:  rd_mux = bg_index | 8'h40;
      SEL_BCPD:  rd_mux = bg_rd;
      SEL_OCPS:  rd_mux = obj_index | 8'h40;
      SEL_OCPD:  rd_mux = obj_rd;
      default:   rd_mux = 8'hFF;
    endcase
  end

  always_comb begin
    read_data_nxt  = is_rd ? rd_mux : 8'h00;
    pal_update_nxt = bg_data_we || obj_data_we;
    pal_obj_nxt    = obj_data_we;
    pal_nxt        = '0;
    if (bg_data_we) begin
      pal_nxt = bg_upd;
    end else if (obj_data_we) begin
      pal_nxt = obj_upd;
    end
    copy_src_nxt = hstat.copy_valid ? h_copy_src : 16'h0000;
    copy_dst_nxt = hstat.copy_valid ? h_copy_dst : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b1;
      vram_bank_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        color_mode_r <= cfg_color_mode;
      end
      if (is_wr && color_mode_r && (in_register_select == SEL_VBK)) begin
        vram_bank_r <= in_write_data[0];
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data_r  <= read_data_nxt;
      pal_update_r <= pal_update_nxt;
      pal_obj_r    <= pal_obj_nxt;
      pal_r        <= pal_nxt;
      copy_valid_r <= hstat.copy_valid;
      copy_src_r   <= copy_src_nxt;
      copy_dst_r   <= copy_dst_nxt;
      done_r       <= hstat.done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = read_data_r;
  assign out_palette_update = pal_update_r;
  assign out_palette_is_obj = pal_obj_r;
  assign out_palette_number = pal_r.palette_number;
  assign out_color_number   = pal_r.color_number;
  assign out_color_rgb      = pal_r.rgb;
  assign out_copy_valid     = copy_valid_r;
  assign out_copy_source    = copy_src_r;
  assign out_copy_dest      = copy_dst_r;
  assign out_transfer_done  = done_r;

  `CGB_ASSERT_NEVER(a_pal_and_copy, clk, rst_n, out_valid_r && pal_update_r && copy_valid_r)
  `CGB_ASSERT_PROP(a_done_stops, clk, rst_n, (in_fire && hstat.done) |=> !hstat.active)
  `CGB_ASSERT_PROP(a_fire_fills, clk, rst_n, in_fire |=> out_valid_r)

endmodule
